/* hdl/threshold_level_run_encoder_unit_macros.svh */
// ---------------------------------------------------------------------------
// Threshold level run encoder assertion macros
// Shared concurrent assertion forms for the encoder checker.
// ---------------------------------------------------------------------------
`ifndef THRESHOLD_LEVEL_RUN_ENCODER_UNIT_MACROS_SVH
`define THRESHOLD_LEVEL_RUN_ENCODER_UNIT_MACROS_SVH

// same-cycle implication, masked during reset
`define TLRE_ASSERT_NOW(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("tlre check failed");

// next-cycle implication, masked during reset
`define TLRE_ASSERT_NEXT(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("tlre check failed");

`endif

/* hdl/tlre_pkg.sv */
// ---------------------------------------------------------------------------
// Threshold level run encoder package
// Shared widths, parameter defaults and cell control type.
// ---------------------------------------------------------------------------
`default_nettype none

package tlre_pkg;

   localparam int MAX_LEVEL_DEF  = 63;
   localparam int INDEX_BITS_DEF = 16;
   localparam int SAMPLE_W       = 6;
   localparam int LEVEL_OUT_W    = 6;

   // per-cycle control broadcast to every cell of the ring
   typedef struct packed {
      logic load;   // open levels (old, new] at the current time index
      logic shift;  // rotate the ring one cell toward the top
   } cell_ctl_type;

endpackage

`default_nettype wire

/* hdl/tlre_req_if.sv */
// ---------------------------------------------------------------------------
// Encoder request channel
// Valid/ready channel carrying one signal sample per beat.
// ---------------------------------------------------------------------------
`default_nettype none

interface tlre_req_if;
   logic                             valid;
   logic                             ready;
   logic [tlre_pkg::SAMPLE_W-1:0]    sample;
   logic                             end_of_signal;

   modport source (output valid, output sample, output end_of_signal, input ready);
   modport sink   (input valid, input sample, input end_of_signal, output ready);
endinterface

`default_nettype wire

/* hdl/tlre_rsp_if.sv */
// ---------------------------------------------------------------------------
// Encoder response channel
// Valid/ready channel carrying one closed run interval per beat.
// ---------------------------------------------------------------------------
`default_nettype none

interface tlre_rsp_if #(
   parameter int INDEX_BITS = tlre_pkg::INDEX_BITS_DEF
);
   logic                               valid;
   logic                               ready;
   logic [INDEX_BITS-1:0]              run_start;
   logic [INDEX_BITS-1:0]              run_end;
   logic [tlre_pkg::LEVEL_OUT_W-1:0]   level;
   logic                               signal_done;
   logic                               last;

   modport source (output valid, output run_start, output run_end, output level,
                   output signal_done, output last, input ready);
   modport sink   (input valid, input run_start, input run_end, input level,
                   input signal_done, input last, output ready);
endinterface

`default_nettype wire

/* hdl/tlre_cell.sv */
// ---------------------------------------------------------------------------
// Encoder ring cell
// Holds the run start index of one level; loads on open, rotates on close.
// ---------------------------------------------------------------------------
`default_nettype none

module tlre_cell #(
   parameter int LEVEL = 1,
   parameter int LW    = 6,
   parameter int IW    = tlre_pkg::INDEX_BITS_DEF
) (
   input  wire logic                   clock,
   input  wire tlre_pkg::cell_ctl_type ctl,
   input  wire logic [LW-1:0]          old_lvl,
   input  wire logic [LW-1:0]          new_lvl,
   input  wire logic [IW-1:0]          time_val,
   input  wire logic [IW-1:0]          ring_in,
   output logic      [IW-1:0]          start_out
);

   localparam logic [LW-1:0] MyLevel = LW'(LEVEL);

   logic [IW-1:0] start_ff;
   logic          open_hit;

   // level opens when the sample rises through it
   assign open_hit = (old_lvl < MyLevel) && (MyLevel <= new_lvl);

   always_ff @(posedge clock) begin
      if (ctl.load && open_hit) begin
         start_ff <= time_val;
      end else if (ctl.shift) begin
         start_ff <= ring_in;
      end
   end

   assign start_out = start_ff;

endmodule

`default_nettype wire

/* hdl/threshold_level_run_encoder_unit.sv */
// A closing item is accepted, then the ring rotates one cell per step from level MAX_LEVEL
//   down to level 1; each closed level goes from the top cell into the output register.
// One item per cycle while nothing closes and no empty-signal marker is pending; a closing
//   item holds off new samples until the ring is back in place, a marker until it is loaded out.
// An output stall holds the ring only while the top cell has a run to hand off. Reset
//   (synchronous, active high) clears the sample history, time index and control state;
//   per-level start indices are left as they are.
// ---------------------------------------------------------------------------
// Threshold level run encoder
// Per-level run starts kept in a rotating ring of cells; a drop or end of
// signal rotates the ring once and emits each closed level from the top; an empty signal emits a marker.
// ---------------------------------------------------------------------------
`default_nettype none

module threshold_level_run_encoder_unit #(
   parameter int MAX_LEVEL  = tlre_pkg::MAX_LEVEL_DEF,
   parameter int INDEX_BITS = tlre_pkg::INDEX_BITS_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   tlre_req_if.sink  req_bus,
   tlre_rsp_if.source rsp_bus
);

   localparam int LW = $clog2(MAX_LEVEL + 1);
   localparam int IW = INDEX_BITS;

   localparam logic [LW-1:0] TopLevel = LW'(MAX_LEVEL);
   localparam logic [LW-1:0] LvlOne   = LW'(1);
   localparam logic [IW-1:0] IdxMax   = '1;

   // ---------------- sample history and time index ----------------
   logic [LW-1:0] prev_ff, prev_in;
   logic [IW-1:0] time_ff, time_in;
   logic          any_ff, any_in;

   // ---------------- close sweep control ----------------
   logic          busy_ff, busy_in;
   logic          marker_ff, marker_in;
   logic [LW-1:0] cnt_ff, cnt_in;      // level currently held by the top cell
   logic [LW-1:0] lo_ff, lo_in;        // close levels in (lo, hi]
   logic [LW-1:0] hi_ff, hi_in;
   logic [LW-1:0] s_ff, s_in;          // levels above s end at t_cur, others at t_nxt
   logic [IW-1:0] t_cur_ff, t_cur_in;
   logic [IW-1:0] t_nxt_ff, t_nxt_in;
   logic          done_ff, done_in;

   // ---------------- output register ----------------
   logic                               rsp_valid_ff, rsp_valid_in;
   logic [IW-1:0]                      rsp_start_ff, rsp_start_in;
   logic [IW-1:0]                      rsp_end_ff, rsp_end_in;
   logic [tlre_pkg::LEVEL_OUT_W-1:0]   rsp_level_ff, rsp_level_in;
   logic                               rsp_done_ff, rsp_done_in;
   logic                               rsp_last_ff, rsp_last_in;

   // ---------------- beat decode ----------------
   logic          req_fire;
   logic [LW-1:0] smp;
   logic [LW-1:0] hi_new, lo_new;
   logic [IW-1:0] time_next;
   logic          eos;
   logic          slot_free, emit_now, step, load_out;
   logic          will_close, is_marker;

   tlre_pkg::cell_ctl_type ctl;
   logic [IW-1:0]          ring [MAX_LEVEL];

   assign req_bus.ready = !busy_ff;
   assign req_fire      = req_bus.valid && !busy_ff;
   assign eos           = req_bus.end_of_signal;

   // clamp samples above the top level
   assign smp = (32'(req_bus.sample) > MAX_LEVEL) ? TopLevel : LW'(req_bus.sample);

   assign hi_new    = (smp > prev_ff) ? smp : prev_ff;
   assign lo_new    = eos ? '0 : smp;
   assign time_next = (time_ff == IdxMax) ? time_ff : time_ff + LvlOne[0 +: 1];

   assign will_close = hi_new > lo_new;
   assign is_marker  = eos && (hi_new == '0) && !any_ff;

   // output side: register free this cycle if empty or being drained
   assign slot_free = !rsp_valid_ff || rsp_bus.ready;
   assign emit_now  = busy_ff && !marker_ff && (cnt_ff > lo_ff) && (cnt_ff <= hi_ff);
   // ring only advances when the top cell's run, if any, can be handed off
   assign step      = busy_ff && !marker_ff && (!emit_now || slot_free);
   assign load_out  = (step && emit_now) || (busy_ff && marker_ff && slot_free);

   assign ctl.load  = req_fire;
   assign ctl.shift = step;

   // ring of cells: cell i holds level i+1, data moves up, top wraps to bottom
   for (genvar gi = 0; gi < MAX_LEVEL; gi++) begin : g_cell
      tlre_cell #(
         .LEVEL (gi + 1),
         .LW    (LW),
         .IW    (IW)
      ) u_cell (
         .clock     (clock),
         .ctl       (ctl),
         .old_lvl   (prev_ff),
         .new_lvl   (smp),
         .time_val  (time_ff),
         .ring_in   (ring[(gi + MAX_LEVEL - 1) % MAX_LEVEL]),
         .start_out (ring[gi])
      );
   end

   always_comb begin
      prev_in   = prev_ff;
      time_in   = time_ff;
      any_in    = any_ff;
      busy_in   = busy_ff;
      marker_in = marker_ff;
      cnt_in    = cnt_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      s_in      = s_ff;
      t_cur_in  = t_cur_ff;
      t_nxt_in  = t_nxt_ff;
      done_in   = done_ff;

      if (req_fire) begin
         prev_in   = eos ? '0 : smp;
         time_in   = eos ? '0 : time_next;
         any_in    = eos ? 1'b0 : (any_ff || will_close);
         busy_in   = will_close || is_marker;
         marker_in = is_marker;
         cnt_in    = TopLevel;
         lo_in     = lo_new;
         hi_in     = hi_new;
         s_in      = smp;
         t_cur_in  = time_ff;
         t_nxt_in  = time_next;
         done_in   = eos;
      end else if (busy_ff) begin
         if (marker_ff) begin
            if (slot_free) begin
               busy_in   = 1'b0;
               marker_in = 1'b0;
            end
         end else if (step) begin
            cnt_in = cnt_ff - LvlOne;
            // full rotation done: ring is back in place
            if (cnt_ff == LvlOne) begin
               busy_in = 1'b0;
            end
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_start_in = rsp_start_ff;
      rsp_end_in   = rsp_end_ff;
      rsp_level_in = rsp_level_ff;
      rsp_done_in  = rsp_done_ff;
      rsp_last_in  = rsp_last_ff;

      if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end

      if (load_out) begin
         rsp_valid_in = 1'b1;
         if (marker_ff) begin
            rsp_start_in = '0;
            rsp_end_in   = '0;
            rsp_level_in = '0;
            rsp_done_in  = 1'b1;
            rsp_last_in  = 1'b1;
         end else begin
            rsp_start_in = ring[MAX_LEVEL-1];
            rsp_end_in   = (cnt_ff > s_ff) ? t_cur_ff : t_nxt_ff;
            rsp_level_in = tlre_pkg::LEVEL_OUT_W'(cnt_ff);
            rsp_done_in  = done_ff;
            rsp_last_in  = (cnt_ff == lo_ff + LvlOne);
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff      <= '0;
         time_ff      <= '0;
         any_ff       <= 1'b0;
         busy_ff      <= 1'b0;
         marker_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         prev_ff      <= prev_in;
         time_ff      <= time_in;
         any_ff       <= any_in;
         busy_ff      <= busy_in;
         marker_ff    <= marker_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      cnt_ff       <= cnt_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      s_ff         <= s_in;
      t_cur_ff     <= t_cur_in;
      t_nxt_ff     <= t_nxt_in;
      done_ff      <= done_in;
      rsp_start_ff <= rsp_start_in;
      rsp_end_ff   <= rsp_end_in;
      rsp_level_ff <= rsp_level_in;
      rsp_done_ff  <= rsp_done_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.run_start   = rsp_start_ff;
   assign rsp_bus.run_end     = rsp_end_ff;
   assign rsp_bus.level       = rsp_level_ff;
   assign rsp_bus.signal_done = rsp_done_ff;
   assign rsp_bus.last        = rsp_last_ff;

endmodule

`default_nettype wire

/* hdl/tlre_checker.sv */
// ---------------------------------------------------------------------------
// Encoder port checker
// Watches the encoder's ports and checks result beats over time.
// ---------------------------------------------------------------------------
`default_nettype none

`include "threshold_level_run_encoder_unit_macros.svh"

module tlre_checker #(
   parameter int MAX_LEVEL  = tlre_pkg::MAX_LEVEL_DEF,
   parameter int INDEX_BITS = tlre_pkg::INDEX_BITS_DEF
) (
   input wire logic                             clock,
   input wire logic                             reset,
   input wire logic                             rsp_valid,
   input wire logic                             rsp_ready,
   input wire logic [INDEX_BITS-1:0]            rsp_run_start,
   input wire logic [INDEX_BITS-1:0]            rsp_run_end,
   input wire logic [tlre_pkg::LEVEL_OUT_W-1:0] rsp_level,
   input wire logic                             rsp_signal_done,
   input wire logic                             rsp_last
);

   localparam logic LevelsFit = (MAX_LEVEL < 64);

   // stalled beat stays valid and holds its run start, run end and level
   `TLRE_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_run_start) && $stable(rsp_run_end) && $stable(rsp_level))

   // a run never ends before it starts
   `TLRE_ASSERT_NOW(a_run_order, clock, reset, rsp_valid, rsp_run_start <= rsp_run_end)

   // level zero only in the empty-signal marker
   `TLRE_ASSERT_NOW(a_marker_form, clock, reset, LevelsFit && rsp_valid && rsp_level == '0,
      rsp_run_start == '0 && rsp_run_end == '0 && rsp_signal_done && rsp_last)

   // runs closed by a drop carry a real level
   `TLRE_ASSERT_NOW(a_drop_level, clock, reset, LevelsFit && rsp_valid && !rsp_signal_done,
      rsp_level != '0)

endmodule

bind threshold_level_run_encoder_unit tlre_checker #(
   .MAX_LEVEL  (MAX_LEVEL),
   .INDEX_BITS (INDEX_BITS)
) u_tlre_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_bus.valid),
   .rsp_ready       (rsp_bus.ready),
   .rsp_run_start   (rsp_bus.run_start),
   .rsp_run_end     (rsp_bus.run_end),
   .rsp_level       (rsp_bus.level),
   .rsp_signal_done (rsp_bus.signal_done),
   .rsp_last        (rsp_bus.last)
);

`default_nettype wire

/* tb/sv/tb_threshold_level_run_encoder_unit.sv */
// ---------------------------------------------------------------------------
// Threshold level run encoder testbench
// Feeds sample beats through valid/ready with random gaps, predicts every
// closed run interval from its own per-level start table, and checks each
// result beat against the oldest prediction. Covers empty signals, full
// flushes, drops to zero, equal and rising samples.
// ---------------------------------------------------------------------------
module tb_threshold_level_run_encoder_unit;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_LEVEL   = tlre_pkg::MAX_LEVEL_DEF;
   localparam int INDEX_BITS  = tlre_pkg::INDEX_BITS_DEF;
   localparam int RANDOM_ITEMS = 100;
   // worst closing item: a full ring rotation, each beat may wait a long stall
   localparam int CYCLE_LIMIT = 2_000_000;

   typedef struct {
      logic [tlre_pkg::SAMPLE_W-1:0] sample;
      logic                          end_of_signal;
      int unsigned                   idle_after;   // idle cycles after this beat
   } sample_beat_type;

   typedef struct {
      logic [INDEX_BITS-1:0]            run_start;
      logic [INDEX_BITS-1:0]            run_end;
      logic [tlre_pkg::LEVEL_OUT_W-1:0] level;
      logic                             signal_done;
      logic                             last;
   } run_beat_type;

   logic clock;
   logic reset;

   tlre_req_if                            req_bus ();
   tlre_rsp_if #(.INDEX_BITS(INDEX_BITS)) rsp_bus ();

   threshold_level_run_encoder_unit #(
      .MAX_LEVEL  (MAX_LEVEL),
      .INDEX_BITS (INDEX_BITS)
   ) u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // stimulus and expectations
   sample_beat_type sample_queue[$];
   run_beat_type    expected_runs[$];
   int unsigned     samples_queued = 0;
   int unsigned     samples_taken  = 0;
   int unsigned     mismatches     = 0;
   int unsigned     cycle_count    = 0;
   int unsigned     req_idle_pct   = 0;

   // predictor state: start index of each open level, last sample, current index
   logic [INDEX_BITS-1:0]         run_origin [1:MAX_LEVEL];
   logic [tlre_pkg::SAMPLE_W-1:0] last_level     = '0;
   logic [INDEX_BITS-1:0]         time_now       = '0;
   bit                            signal_has_run = 1'b0;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // every input known from time zero
   initial begin
      req_bus.valid         = 1'b0;
      req_bus.sample        = '0;
      req_bus.end_of_signal = 1'b0;
      rsp_bus.ready         = 1'b0;
   end

   // gap length: mostly short, now and then a long one
   function automatic int unsigned pick_gap();
      return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(8, 30);
   endfunction

   // time index saturates at all ones
   function automatic logic [INDEX_BITS-1:0] step_index(input logic [INDEX_BITS-1:0] t);
      return (t == '1) ? t : t + 1'b1;
   endfunction

   // close levels (down_to, from], highest first, all ending at stop
   task automatic close_open_runs(input int from, input int down_to,
                                  input logic [INDEX_BITS-1:0] stop, input logic done);
      run_beat_type beat;
      for (int lvl = from; lvl > down_to; lvl--) begin
         beat.run_start   = run_origin[lvl];
         beat.run_end     = stop;
         beat.level       = tlre_pkg::LEVEL_OUT_W'(lvl);
         beat.signal_done = done;
         beat.last        = 1'b0;
         expected_runs.push_back(beat);
         signal_has_run = 1'b1;
      end
   endtask

   // expected run beats caused by one accepted sample
   task automatic predict_runs(input logic [tlre_pkg::SAMPLE_W-1:0] smp, input logic eos);
      int           lvl;
      int           first_new;
      run_beat_type beat;
      lvl       = (smp > MAX_LEVEL) ? MAX_LEVEL : int'(smp);
      first_new = expected_runs.size();
      if (lvl < last_level) begin
         close_open_runs(last_level, lvl, time_now, eos);
      end else begin
         for (int k = int'(last_level) + 1; k <= lvl; k++) run_origin[k] = time_now;
      end
      last_level = tlre_pkg::SAMPLE_W'(lvl);
      if (eos) begin
         close_open_runs(lvl, 0, step_index(time_now), 1'b1);
         // a signal that never closed a run still reports once
         if (expected_runs.size() == first_new && !signal_has_run) begin
            beat.run_start   = '0;
            beat.run_end     = '0;
            beat.level       = '0;
            beat.signal_done = 1'b1;
            beat.last        = 1'b0;
            expected_runs.push_back(beat);
         end
         last_level     = '0;
         time_now       = '0;
         signal_has_run = 1'b0;
      end else begin
         time_now = step_index(time_now);
      end
      if (expected_runs.size() > first_new) begin
         beat      = expected_runs.pop_back();
         beat.last = 1'b1;
         expected_runs.push_back(beat);
      end
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         mismatches++;
      end
   endtask

   task automatic queue_sample(input int smp, input bit eos);
      sample_beat_type beat;
      beat.sample        = tlre_pkg::SAMPLE_W'(smp);
      beat.end_of_signal = eos;
      beat.idle_after    = ($urandom_range(0, 99) < req_idle_pct) ? pick_gap() : 0;
      sample_queue.push_back(beat);
      samples_queued++;
   endtask

   // Driver: presents the next pending beat, holds it until taken, then
   // idles for the gap that beat carries.
   int unsigned hold_left = 0;
   always @(posedge clock) begin : drive_samples
      sample_beat_type beat;
      if (reset) begin
         req_bus.valid <= 1'b0;
         hold_left = 0;
      end else if (!req_bus.valid || req_bus.ready) begin
         if (hold_left != 0) begin
            req_bus.valid <= 1'b0;
            hold_left--;
         end else if (sample_queue.size() != 0) begin
            beat = sample_queue.pop_front();
            req_bus.sample        <= beat.sample;
            req_bus.end_of_signal <= beat.end_of_signal;
            req_bus.valid         <= 1'b1;
            hold_left = beat.idle_after;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // Result sink: stall rate switches at random among 0, 10 and 35 percent, zero included,
   // so quiet stretches alternate with heavy backpressure.
   int unsigned stall_left    = 0;
   int unsigned mode_left     = 0;
   int unsigned rsp_idle_pct  = 0;
   always @(posedge clock) begin : drive_ready
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (mode_left == 0) begin
            case ($urandom_range(0, 2))
               0: rsp_idle_pct = 0;
               1: rsp_idle_pct = 10;
               default: rsp_idle_pct = 35;
            endcase
            mode_left = $urandom_range(200, 800);
         end else begin
            mode_left--;
         end
         if (stall_left != 0) begin
            rsp_bus.ready <= 1'b0;
            stall_left--;
         end else if ($urandom_range(0, 99) < rsp_idle_pct) begin
            rsp_bus.ready <= 1'b0;
            stall_left = pick_gap() - 1;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // Monitor: a taken sample extends the predictions first, so a result in
   // the same edge still finds its expectation.
   always @(posedge clock) begin : watch_beats
      run_beat_type want;
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            predict_runs(req_bus.sample, req_bus.end_of_signal);
            samples_taken++;
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_runs.size() == 0) begin
               $error("unexpected run beat: level %0d start %0d end %0d",
                      rsp_bus.level, rsp_bus.run_start, rsp_bus.run_end);
               mismatches++;
            end else begin
               want = expected_runs.pop_front();
               check_field("run_start", want.run_start, rsp_bus.run_start);
               check_field("run_end", want.run_end, rsp_bus.run_end);
               check_field("level", want.level, rsp_bus.level);
               check_field("signal_done", want.signal_done, rsp_bus.signal_done);
               check_field("last", want.last, rsp_bus.last);
            end
         end
      end
   end

   // hard stop if the handshakes never finish
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb_threshold_level_run_encoder_unit: FAIL");
         $finish;
      end
   end

   initial begin : stimulus
      int  random_items;
      int  len;
      int  style;
      int  smp;
      int  walk;
      bit  eos;

      reset = 1'b1;

      // --- directed ---
      req_idle_pct = 30;
      queue_sample(0, 1);              // empty signal: marker only
      queue_sample(63, 1);             // single top sample: full flush 63..1
      queue_sample(0, 0);              // rise to top, drop to zero,
      queue_sample(63, 0);             // then a final zero closes nothing
      queue_sample(0, 0);
      queue_sample(0, 1);
      queue_sample(2, 0);              // mixed rises, equal, partial drops
      queue_sample(5, 0);
      queue_sample(5, 0);
      queue_sample(3, 0);
      queue_sample(7, 0);
      queue_sample(1, 1);              // final drop, then flush of level 1
      queue_sample(4, 0);              // equal final sample flushes
      queue_sample(4, 1);
      queue_sample(0, 0);              // all zeros: marker
      queue_sample(0, 0);
      queue_sample(0, 1);
      queue_sample(63, 0);             // rise to top, drop to one, back to top at the end
      queue_sample(1, 0);
      queue_sample(63, 1);

      // --- random signals, each closed by its final sample ---
      random_items = 0;
      while (random_items < RANDOM_ITEMS) begin
         case ($urandom_range(0, 2))
            0: req_idle_pct = 0;
            1: req_idle_pct = 20;
            default: req_idle_pct = 50;
         endcase
         len   = $urandom_range(1, 10);
         style = $urandom_range(0, 9);
         walk  = $urandom_range(0, 63);
         for (int i = 0; i < len; i++) begin
            eos = (i == len - 1);
            case (style)
               0, 1, 2, 3: smp = $urandom_range(0, 63);
               4, 5:       smp = $urandom_range(0, 7);
               6:          smp = $urandom_range(0, 1) ? 63 : 0;
               7:          smp = 0;
               8:          smp = eos ? 0 : $urandom_range(1, 63);
               default: begin
                  walk += int'($urandom_range(0, 6)) - 3;
                  walk = (walk < 0) ? 0 : (walk > 63) ? 63 : walk;
                  smp  = walk;
               end
            endcase
            queue_sample(smp, eos);
         end
         random_items += len;
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      while (samples_taken != samples_queued) @(posedge clock);
      while (expected_runs.size() != 0) @(posedge clock);
      // let any stray beat from a full ring rotation show up
      repeat (4 * (MAX_LEVEL + 1)) @(posedge clock);

      if (mismatches == 0 && expected_runs.size() == 0) begin
         $display("tb_threshold_level_run_encoder_unit: PASS");
      end else begin
         $display("tb_threshold_level_run_encoder_unit: FAIL");
      end
      $finish;
   end

endmodule
